/* design/pcfp_pkg.sv */
// Shared types and constants of the panel command frame parser.
package pcfp_pkg;

  localparam logic [7:0] HDR_BYTE     = 8'h55;
  localparam logic [7:0] TAIL_BYTE    = 8'hFF;
  localparam logic [7:0] SNOOZE_B1    = 8'hEE;
  localparam logic [7:0] SNOOZE_B2    = 8'h01;
  localparam logic [7:0] CONFIRM7_B1  = 8'hAA;
  localparam logic [7:0] CONFIRM7_B2  = 8'h01;
  localparam logic [7:0] CONFIRM7_B3  = 8'h0D;
  localparam logic [7:0] HOUR_LIMIT   = 8'd24;
  localparam logic [7:0] MINUTE_LIMIT = 8'd60;
  localparam logic [7:0] MED_BP       = 8'd1;
  localparam logic [7:0] MED_SUGAR    = 8'd2;
  localparam logic [1:0] CMD_PLAIN    = 2'd2;

  localparam logic [2:0] LEN_SHORT = 3'd6;
  localparam logic [2:0] LEN_LONG  = 3'd7;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_CONFIRM = 3'd2,
    EV_PLAIN   = 3'd3,
    EV_SNOOZE  = 3'd4,
    EV_TYPED   = 3'd5
  } event_t;

  typedef struct packed {
    event_t     evt;
    logic       set_alarm;
    logic       set_med;
    logic [1:0] cmd;
  } cls_res_t;

endpackage

/* design/pcfp_if.sv */
// Valid/ready channel interfaces for received bytes and parser results.
interface pcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pcfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       frame_done;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [1:0] command_out;
  logic [1:0] medicine_out;
  logic [2:0] diag_out;

  modport source (output valid, output event_res, output frame_done, output hour_out,
                  output minute_out, output command_out, output medicine_out,
                  output diag_out, input ready);
  modport sink   (input valid, input event_res, input frame_done, input hour_out,
                  input minute_out, input command_out, input medicine_out,
                  input diag_out, output ready);
endinterface

/* design/pcfp_classify.sv */
// Frame classifier: decides the event of a frame whose tail has been seen.
module pcfp_classify (
  input  logic              long_frame,
  input  logic [7:0]        b1,
  input  logic [7:0]        b2,
  input  logic [7:0]        b3,
  output pcfp_pkg::cls_res_t res
);
  import pcfp_pkg::*;

  logic time_ok;

  assign time_ok = (b1 < HOUR_LIMIT) && (b2 < MINUTE_LIMIT);

  always_comb begin
    res.evt       = EV_NONE;
    res.set_alarm = 1'b0;
    res.set_med   = 1'b0;
    res.cmd       = CMD_PLAIN;
    if (!long_frame) begin
      if (b1 == SNOOZE_B1 && b2 == SNOOZE_B2) begin
        res.evt = EV_SNOOZE;
      end else if (b1 == TAIL_BYTE && b2 == TAIL_BYTE) begin
        res.evt = EV_CONFIRM;
      end else if (time_ok) begin
        res.evt       = EV_PLAIN;
        res.set_alarm = 1'b1;
      end
    end else begin
      if (b1 == CONFIRM7_B1 && b2 == CONFIRM7_B2 && b3 == CONFIRM7_B3) begin
        res.evt = EV_CONFIRM;
      end else if (time_ok && (b3 == MED_BP || b3 == MED_SUGAR)) begin
        res.evt       = EV_TYPED;
        res.set_alarm = 1'b1;
        res.set_med   = 1'b1;
        res.cmd       = b3[1:0];
      end
    end
  end

endmodule

/* design/panel_command_frame_parser_unit.sv */
// Top level of the panel command frame parser.
// The parser takes received panel bytes on the in_ch channel, one per transfer,
// and returns exactly one result per byte on the out_ch channel.
// A frame opens with 0x55 and closes with three 0xFF bytes after six or seven
// bytes in total; a 0x55 inside an open frame restarts it.
// Each result carries the event code, a frame_done flag for valid frames, and
// the stored alarm hour, minute, command, medicine type and diagnostic code
// as they stand after that byte.
// A byte passes through an input register and a result register, so its
// result is on out_ch once it has left the input register, and it is taken
// at an edge where the receiver is ready.
// One byte can be taken in every cycle while out_ch is not stalled; the frame
// counter and the byte store update as a byte passes between the registers.
// When the receiver stalls, the result register holds its value, the byte in
// the input register waits, and in_ch.ready falls once both are full.
// Synchronous reset closes any open frame and clears the stored alarm fields,
// the medicine type and the diagnostic code; both registers become empty.
module panel_command_frame_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  pcfp_in_if.sink        in_ch,
  pcfp_out_if.source     out_ch
);
  import pcfp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       s1_adv;
  logic       s1_fire;

  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] st_r [5];
  logic       st_we;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [1:0] med_r, med_nxt;
  logic [2:0] diag_r, diag_nxt;
  event_t     ev_r, ev_nxt;
  logic       done_r, done_nxt;

  logic       is_hdr;
  logic [2:0] n_new;
  logic       tail_ok;
  cls_res_t   cls;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  assign is_hdr = (s1_byte_r == HDR_BYTE);
  assign n_new  = cnt_r + 3'd1;

  always_comb begin
    tail_ok = 1'b0;
    if (n_new == LEN_SHORT) begin
      tail_ok = (st_r[2] == TAIL_BYTE) && (st_r[3] == TAIL_BYTE) && (s1_byte_r == TAIL_BYTE);
    end else if (n_new == LEN_LONG) begin
      tail_ok = (st_r[3] == TAIL_BYTE) && (st_r[4] == TAIL_BYTE) && (s1_byte_r == TAIL_BYTE);
    end
  end

  pcfp_classify u_classify (
    .long_frame (n_new == LEN_LONG),
    .b1         (st_r[0]),
    .b2         (st_r[1]),
    .b3         (st_r[2]),
    .res        (cls)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    cmd_nxt    = cmd_r;
    med_nxt    = med_r;
    diag_nxt   = diag_r;
    ev_nxt     = EV_NONE;
    done_nxt   = 1'b0;
    st_we      = 1'b0;
    if (is_hdr) begin
      cnt_nxt  = 3'd1;
      ev_nxt   = EV_HEADER;
      diag_nxt = 3'(EV_HEADER);
    end else if (cnt_r == 3'd0) begin
      cnt_nxt = 3'd0;
    end else if (cnt_r >= LEN_LONG) begin
      cnt_nxt = 3'd0;
    end else begin
      st_we = 1'b1;
      if (tail_ok) begin
        cnt_nxt = 3'd0;
        ev_nxt  = cls.evt;
        if (cls.evt != EV_NONE) begin
          done_nxt = 1'b1;
          diag_nxt = 3'(cls.evt);
        end
        if (cls.set_alarm) begin
          hour_nxt   = st_r[0][4:0];
          minute_nxt = st_r[1][5:0];
          cmd_nxt    = cls.cmd;
        end
        if (cls.set_med) begin
          med_nxt = cls.cmd;
        end
      end else if (n_new == LEN_LONG) begin
        cnt_nxt = 3'd0;
      end else begin
        cnt_nxt = n_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      if (s1_fire && st_we && cnt_r == 3'(i + 1)) begin
        st_r[i] <= s1_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      hour_r      <= 5'd0;
      minute_r    <= 6'd0;
      cmd_r       <= 2'd0;
      med_r       <= 2'd0;
      diag_r      <= 3'd0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        cnt_r    <= cnt_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        cmd_r    <= cmd_nxt;
        med_r    <= med_nxt;
        diag_r   <= diag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ev_r   <= ev_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = ev_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.hour_out     = hour_r;
  assign out_ch.minute_out   = minute_r;
  assign out_ch.command_out  = cmd_r;
  assign out_ch.medicine_out = med_r;
  assign out_ch.diag_out     = diag_r;

  // A frame never stays open past its seventh byte.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != LEN_LONG)
    else $error("frame counter reached seven");

  a_hdr_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_hdr) |=> (cnt_r == 3'd1 && diag_r == 3'(EV_HEADER)))
    else $error("header byte did not open a frame");

  a_done_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (ev_r != EV_NONE && ev_r != EV_HEADER))
    else $error("frame_done without a frame event");

  a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r < 5'd24) && (minute_r < 6'd60))
    else $error("stored alarm time out of range");

  a_cmd_med: assert property (@(posedge clk) disable iff (!rst_n)
    (med_r != 2'd0) |-> (cmd_r == med_r || cmd_r == CMD_PLAIN))
    else $error("alarm command inconsistent with medicine type");

endmodule
